### hdl/ctdm_pkg.sv
// ----------------------------------------------------------------------------
// ctdm_pkg
// Types, codes and helpers shared by the card table dirty mark unit.
// ----------------------------------------------------------------------------
package ctdm_pkg;

    localparam int ADDR_W     = 48;
    localparam int CIDX_W     = 12;
    localparam int CNT_W      = 13;
    localparam int CARD_SHIFT = 9;
    localparam int ROW_BITS   = 32;
    localparam int CMD_W      = 3;

    localparam logic [CMD_W-1:0] CMD_MARK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TEST      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd4;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_CARD_COUNT = 1'b1;

    typedef enum logic [2:0] {
        K_MARK,
        K_TEST,
        K_CLEAR,
        K_CLRALL,
        K_FIND,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_FIND
    } t_bstate;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [CIDX_W-1:0] card_index;
    } t_cmd_item;

    typedef struct packed {
        logic              hit;
        logic [CIDX_W-1:0] found_index;
        logic [ADDR_W-1:0] card_start;
        logic [ADDR_W-1:0] card_end;
        logic [CNT_W-1:0]  dirty_total;
    } t_result;

    // Classified command. An index in range is always below the card count.
    typedef struct packed {
        t_kind            kind;
        logic             in_range;
        logic [CNT_W-1:0] idx;
    } t_op;

    // Result before the card addresses are formed.
    typedef struct packed {
        logic              hit;
        logic              addr_ok;
        logic [CIDX_W-1:0] idx;
        logic [CNT_W-1:0]  total;
    } t_raw;

    function automatic logic [4:0] first_set(input logic [ROW_BITS-1:0] bits);
        logic [4:0] pos;
        pos = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (bits[b]) begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

endpackage

### hdl/card_table_dirty_marks_unit.sv
// ----------------------------------------------------------------------------
// card_table_dirty_marks_unit
// Card table with one dirty bit per 512-byte card of a configured heap.
//
//   Channel   Handshake                Payload
//   command   push / full              i_item   (t_cmd_item)
//   result    pop / empty              o_result (t_result)
//   config    i_cfg_we, i_cfg_idx      i_cfg_data (48 bits)
//
// Mark, test and clear read the card's row in the row engine; mark and clear then write it.
// A find scans 32-card rows in turn, from the row of the start card onward.
// Clear all walks every row, one per cycle.
// After reset and after any configuration write the same sweep runs with full high.
// Results pass an address stage and a two-entry queue; commands queue two deep.
// ----------------------------------------------------------------------------
module card_table_dirty_marks_unit import ctdm_pkg::*; #(
    parameter int MAX_CARDS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_cmd_item         i_item,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    localparam int CAP = (MAX_CARDS < 8191) ? MAX_CARDS : 8191;

    logic [ADDR_W-1:0] r_heap_base;
    logic [CNT_W-1:0]  r_card_count;
    logic [CNT_W-1:0]  w_n;
    t_op               w_op;
    logic              w_op_vld;
    logic              w_op_pop;
    t_raw              w_raw;
    logic              w_raw_vld;
    logic              w_raw_rdy;
    logic              w_init;

    assign w_n = (r_card_count > CNT_W'(CAP)) ? CNT_W'(CAP) : r_card_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_card_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                CFG_CARD_COUNT: r_card_count <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    ctdm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_hold   (w_init),
        .i_item   (i_item),
        .i_base   (r_heap_base),
        .i_n      (w_n),
        .o_op     (w_op),
        .o_op_vld (w_op_vld),
        .i_op_pop (w_op_pop)
    );

    ctdm_back #(
        .MAX_CARDS (MAX_CARDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wipe    (i_cfg_we),
        .i_n       (w_n),
        .i_op      (w_op),
        .i_op_vld  (w_op_vld),
        .o_op_pop  (w_op_pop),
        .o_raw     (w_raw),
        .o_raw_vld (w_raw_vld),
        .i_raw_rdy (w_raw_rdy),
        .o_init    (w_init)
    );

    ctdm_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raw     (w_raw),
        .i_raw_vld (w_raw_vld),
        .o_raw_rdy (w_raw_rdy),
        .i_base    (r_heap_base),
        .o_res     (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    // The dirty count never exceeds the number of cards in use.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.dirty_total <= w_n))
        else $error("dirty total above card count");

    // Every result that carries card addresses has its end one card past its start.
    a_card_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_result.card_start != '0) || (o_result.card_end != '0))) |->
        (o_result.card_end == ADDR_W'(o_result.card_start + 48'd512)))
        else $error("card end does not follow card start");

    // A configuration write starts the clearing sweep and holds off commands.
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> full)
        else $error("command accepted during clearing sweep");

endmodule

### hdl/ctdm_front.sv
// ----------------------------------------------------------------------------
// ctdm_front
// Accepts commands, turns them into card operations and queues them.
// ----------------------------------------------------------------------------
module ctdm_front import ctdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_hold,
    input  t_cmd_item         i_item,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [CNT_W-1:0]  i_n,
    output t_op               o_op,
    output logic              o_op_vld,
    input  logic              i_op_pop
);

    localparam int CI_W = ADDR_W - CARD_SHIFT;

    logic [ADDR_W:0]   w_diff;
    logic [CI_W-1:0]   w_cidx;
    logic              w_mark_in;
    logic              w_ci_in;
    t_op               w_op;
    logic              w_wr;
    logic              w_rd;
    t_op               r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign w_diff    = {1'b0, i_item.addr} - {1'b0, i_base};
    assign w_cidx    = w_diff[ADDR_W-1:CARD_SHIFT];
    assign w_mark_in = !w_diff[ADDR_W] && (w_cidx < {{(CI_W-CNT_W){1'b0}}, i_n});
    assign w_ci_in   = {1'b0, i_item.card_index} < i_n;

    always_comb begin
        w_op = '{kind: K_NOP, in_range: 1'b0, idx: '0};
        unique case (i_item.cmd)
            CMD_MARK: begin
                w_op.kind     = K_MARK;
                w_op.in_range = w_mark_in;
                w_op.idx      = w_mark_in ? w_cidx[CNT_W-1:0] : '0;
            end
            CMD_TEST: begin
                w_op.kind     = K_TEST;
                w_op.in_range = w_ci_in;
                w_op.idx      = {1'b0, i_item.card_index};
            end
            CMD_CLEAR: begin
                w_op.kind     = K_CLEAR;
                w_op.in_range = w_ci_in;
                w_op.idx      = {1'b0, i_item.card_index};
            end
            CMD_CLEAR_ALL: begin
                w_op.kind = K_CLRALL;
            end
            CMD_FIND: begin
                w_op.kind     = K_FIND;
                w_op.in_range = w_ci_in;
                w_op.idx      = {1'b0, i_item.card_index};
            end
            default: begin
                w_op.kind = K_NOP;
            end
        endcase
    end

    assign o_full   = (r_cnt == 2'd2) || i_hold;
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_op_pop && (r_cnt != 2'd0);
    assign o_op_vld = (r_cnt != 2'd0);
    assign o_op     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_op;
        end
    end

endmodule

### hdl/ctdm_back.sv
// ----------------------------------------------------------------------------
// ctdm_back
// Holds the dirty bits in rows of a memory and carries out card operations.
// ----------------------------------------------------------------------------
module ctdm_back import ctdm_pkg::*; #(
    parameter int MAX_CARDS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wipe,
    input  logic [CNT_W-1:0] i_n,
    input  t_op              i_op,
    input  logic             i_op_vld,
    output logic             o_op_pop,
    output t_raw             o_raw,
    output logic             o_raw_vld,
    input  logic             i_raw_rdy,
    output logic             o_init
);

    localparam int ROWS = (MAX_CARDS + ROW_BITS - 1) / ROW_BITS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VW   = ((RW + 5 > CNT_W) ? RW + 5 : CNT_W) + 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    t_bstate               r_state;
    t_bstate               n_state;
    logic [RW-1:0]         r_row;
    logic [RW-1:0]         n_row;
    t_op                   r_op;
    t_op                   n_op;
    logic                  r_first;
    logic                  n_first;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_clr_rsp;
    logic                  n_clr_rsp;
    logic [ROW_BITS-1:0]   r_mem [ROWS];
    logic [ROW_BITS-1:0]   r_rdata;
    logic                  w_rd_en;
    logic [RW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [RW-1:0]         w_wr_addr;
    logic [ROW_BITS-1:0]   w_wr_data;
    logic [31:0]           w_op_row32;
    logic [RW-1:0]         w_op_row;
    logic                  w_bit;
    logic [VW-1:0]         w_rowbase;
    logic [VW-1:0]         w_n_ext;
    logic [VW-1:0]         w_rem;
    logic [ROW_BITS-1:0]   w_lim;
    logic [ROW_BITS-1:0]   w_low;
    logic [ROW_BITS-1:0]   w_hits;
    logic                  w_more;
    logic [31:0]           w_found32;

    assign w_op_row32 = 32'(i_op.idx[CNT_W-1:5]);
    assign w_op_row   = w_op_row32[RW-1:0];
    assign w_bit      = r_rdata[r_op.idx[4:0]];

    assign w_rowbase = {{(VW-RW-5){1'b0}}, r_row, 5'b0};
    assign w_n_ext   = {{(VW-CNT_W){1'b0}}, i_n};
    assign w_rem     = w_n_ext - w_rowbase;
    assign w_lim     = (w_n_ext <= w_rowbase) ? '0 :
                       (w_rem >= VW'(ROW_BITS)) ? '1 :
                       ~({ROW_BITS{1'b1}} << w_rem[4:0]);
    assign w_low     = r_first ? ({ROW_BITS{1'b1}} << r_op.idx[4:0]) : '1;
    assign w_hits    = r_rdata & w_low & w_lim;
    assign w_more    = (w_rowbase + VW'(ROW_BITS)) < w_n_ext;
    assign w_found32 = 32'({r_row, first_set(w_hits)});

    assign o_init = (r_state == BS_CLEAR) && !r_clr_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_op      = r_op;
        n_first   = r_first;
        n_count   = r_count;
        n_clr_rsp = r_clr_rsp;
        w_rd_en   = 1'b0;
        w_rd_addr = r_row;
        w_wr_en   = 1'b0;
        w_wr_addr = r_row;
        w_wr_data = r_rdata;
        o_op_pop  = 1'b0;
        o_raw_vld = 1'b0;
        o_raw     = '0;
        unique case (r_state)
            BS_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
                n_row     = r_row + RW'(1);
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = r_clr_rsp ? BS_EXEC : BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_op_vld) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    if (i_op.kind == K_CLRALL) begin
                        n_state   = BS_CLEAR;
                        n_row     = '0;
                        n_clr_rsp = 1'b1;
                        n_count   = '0;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_op_row;
                        n_row     = w_op_row;
                        n_first   = 1'b1;
                        n_state   = (i_op.kind == K_FIND) ? BS_FIND : BS_EXEC;
                    end
                end
            end
            BS_EXEC: begin
                if (i_raw_rdy) begin
                    o_raw_vld = 1'b1;
                    n_state   = BS_IDLE;
                    n_clr_rsp = 1'b0;
                    case (r_op.kind)
                        K_MARK: begin
                            if (r_op.in_range && !w_bit) begin
                                w_wr_en                  = 1'b1;
                                w_wr_data[r_op.idx[4:0]] = 1'b1;
                                n_count                  = r_count + CNT_W'(1);
                            end
                            o_raw.hit     = r_op.in_range;
                            o_raw.addr_ok = r_op.in_range;
                            o_raw.idx     = r_op.idx[CIDX_W-1:0];
                        end
                        K_TEST: begin
                            o_raw.hit     = r_op.in_range && w_bit;
                            o_raw.addr_ok = 1'b1;
                            o_raw.idx     = r_op.idx[CIDX_W-1:0];
                        end
                        K_CLEAR: begin
                            if (r_op.in_range && w_bit) begin
                                w_wr_en                  = 1'b1;
                                w_wr_data[r_op.idx[4:0]] = 1'b0;
                                n_count                  = r_count - CNT_W'(1);
                            end
                            o_raw.hit     = r_op.in_range;
                            o_raw.addr_ok = 1'b1;
                            o_raw.idx     = r_op.idx[CIDX_W-1:0];
                        end
                        K_CLRALL: begin
                            o_raw.hit = 1'b1;
                        end
                        default: begin
                            o_raw.hit = 1'b0;
                        end
                    endcase
                    o_raw.total = n_count;
                end
            end
            BS_FIND: begin
                if (!r_op.in_range || (w_hits == '0)) begin
                    if (r_op.in_range && w_more) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_row + RW'(1);
                        n_row     = r_row + RW'(1);
                        n_first   = 1'b0;
                    end else if (i_raw_rdy) begin
                        o_raw_vld   = 1'b1;
                        o_raw.total = r_count;
                        n_state     = BS_IDLE;
                    end
                end else if (i_raw_rdy) begin
                    o_raw_vld     = 1'b1;
                    o_raw.hit     = 1'b1;
                    o_raw.addr_ok = 1'b1;
                    o_raw.idx     = w_found32[CIDX_W-1:0];
                    o_raw.total   = r_count;
                    n_state       = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
        if (i_wipe) begin
            n_state   = BS_CLEAR;
            n_row     = '0;
            n_count   = '0;
            n_clr_rsp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_count   <= '0;
            r_clr_rsp <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_count   <= n_count;
            r_clr_rsp <= n_clr_rsp;
            r_first   <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

endmodule

### hdl/ctdm_out.sv
// ----------------------------------------------------------------------------
// ctdm_out
// Forms card start and end addresses and queues finished results.
// ----------------------------------------------------------------------------
module ctdm_out import ctdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_raw              i_raw,
    input  logic              i_raw_vld,
    output logic              o_raw_rdy,
    input  logic [ADDR_W-1:0] i_base,
    output t_result           o_res,
    output logic              o_empty,
    input  logic              i_pop
);

    localparam int PAD_W = ADDR_W - CIDX_W - CARD_SHIFT;

    t_raw              r_stg;
    logic              r_stg_vld;
    t_result           r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    t_result           w_res;
    logic              w_mv;
    logic              w_pop;
    logic [CIDX_W:0]   w_idx_p1;

    assign w_mv      = r_stg_vld && (r_cnt != 2'd2);
    assign o_raw_rdy = !r_stg_vld || w_mv;
    assign w_pop     = i_pop && (r_cnt != 2'd0);
    assign w_idx_p1  = {1'b0, r_stg.idx} + (CIDX_W + 1)'(1);

    always_comb begin
        w_res.hit         = r_stg.hit;
        w_res.found_index = r_stg.addr_ok ? r_stg.idx : '0;
        w_res.dirty_total = r_stg.total;
        w_res.card_start  = '0;
        w_res.card_end    = '0;
        if (r_stg.addr_ok) begin
            w_res.card_start = i_base + {{PAD_W{1'b0}}, r_stg.idx, {CARD_SHIFT{1'b0}}};
            w_res.card_end   = i_base + {{(PAD_W-1){1'b0}}, w_idx_p1, {CARD_SHIFT{1'b0}}};
        end
    end

    assign o_res   = r_q[r_rp];
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (o_raw_rdy) begin
                r_stg_vld <= i_raw_vld;
            end
            if (w_mv) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_mv} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_raw_rdy && i_raw_vld) begin
            r_stg <= i_raw;
        end
        if (w_mv) begin
            r_q[r_wp] <= w_res;
        end
    end

endmodule
